### hw/rtl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and UTF-8 encode helpers for the UTF-16 to UTF-8
// transcoder with source offsets.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int OFS_W    = 32;
    localparam int CP_W     = 21;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int OUT_W    = 32;
    localparam int MDATA_W  = 8 + OUT_W + OUT_W;

    localparam logic [5:0]      HI_SURR_TAG  = 6'b110110;
    localparam logic [5:0]      LO_SURR_TAG  = 6'b110111;
    localparam logic [CP_W-1:0] CP_REPL      = CP_W'(32'hFFFD);
    localparam logic [CP_W-1:0] CP_SUPP_BASE = CP_W'(32'h10000);
    localparam logic [CP_W-1:0] CP_LIM1      = CP_W'(32'h80);
    localparam logic [CP_W-1:0] CP_LIM2      = CP_W'(32'h800);
    localparam logic [CP_W-1:0] CP_LIM3      = CP_W'(32'h10000);
    localparam logic [7:0]      LEAD2        = 8'hC0;
    localparam logic [7:0]      LEAD3        = 8'hE0;
    localparam logic [7:0]      LEAD4        = 8'hF0;
    localparam logic [7:0]      CONT         = 8'h80;

    typedef enum logic [1:0] {
        SEG_A,
        SEG_B,
        SEG_SUM
    } t_seg;

    typedef struct packed {
        logic              a_v;
        logic [CP_W-1:0]   cp_a;
        logic [OFS_W-1:0]  ofs_a;
        logic              b_v;
        logic [CP_W-1:0]   cp_b;
        logic [OFS_W-1:0]  ofs_b;
        logic              sum_v;
        logic [OFS_W-1:0]  consumed;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // number of utf-8 bytes minus one
    function automatic logic [1:0] utf8_len_m1(input logic [CP_W-1:0] cp);
        logic [1:0] len;
        if (cp < CP_LIM1) begin
            len = 2'd0;
        end else if (cp < CP_LIM2) begin
            len = 2'd1;
        end else if (cp < CP_LIM3) begin
            len = 2'd2;
        end else begin
            len = 2'd3;
        end
        return len;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [1:0]      len_m1,
                                             input logic [1:0]      idx);
        logic [7:0] b;
        b = 8'h00;
        unique case (len_m1)
            2'd0: b = {1'b0, cp[6:0]};
            2'd1: b = (idx == 2'd0) ? (LEAD2 | {3'b000, cp[10:6]})
                                    : (CONT | {2'b00, cp[5:0]});
            2'd2: begin
                unique case (idx)
                    2'd0:    b = LEAD3 | {4'b0000, cp[15:12]};
                    2'd1:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            default: begin
                unique case (idx)
                    2'd0:    b = LEAD4 | {5'b00000, cp[20:18]};
                    2'd1:    b = CONT | {2'b00, cp[17:12]};
                    2'd2:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

### hw/rtl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Pairs bytes into code units, pairs surrogates and builds at most one command per
// input word: up to two code points plus an optional window summary.
// ----------------------------------------------------------------------------
module u16u8_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr,
    input  logic                  i_cfg_data,
    input  logic                  i_accept,
    input  logic                  i_has,
    input  logic [7:0]            i_byte,
    input  logic                  i_end,
    output logic                  o_push,
    output u16u8_pkg::t_cmd       o_cmd
);
    import u16u8_pkg::*;

    logic              r_big_endian, n_big_endian;
    logic              r_half_v,     n_half_v;
    logic [7:0]        r_half_byte,  n_half_byte;
    logic              r_hp,         n_hp;
    logic [9:0]        r_hbits,      n_hbits;
    logic [OFS_W-1:0]  r_hofs,       n_hofs;
    logic [OFS_W-1:0]  r_pos,        n_pos;

    logic [15:0]       w_unit;
    logic [OFS_W-1:0]  w_ofs;
    logic              w_is_hi;
    logic              w_is_lo;
    logic              w_alone;
    logic              w_alone_b;
    logic              w_slot_v;
    logic [CP_W-1:0]   w_slot_cp;
    t_cmd              w_cmd;

    assign w_unit  = r_big_endian ? {r_half_byte, i_byte} : {i_byte, r_half_byte};
    assign w_ofs   = r_pos - OFS_W'(1);
    assign w_is_hi = (w_unit[15:10] == HI_SURR_TAG);
    assign w_is_lo = (w_unit[15:10] == LO_SURR_TAG);

    always_comb begin
        n_big_endian = i_cfg_wr ? i_cfg_data : r_big_endian;
        n_half_v     = r_half_v;
        n_half_byte  = r_half_byte;
        n_hp         = r_hp;
        n_hbits      = r_hbits;
        n_hofs       = r_hofs;
        n_pos        = r_pos;
        w_cmd        = '0;
        w_alone      = 1'b0;
        w_alone_b    = 1'b0;
        w_slot_v     = 1'b0;
        w_slot_cp    = '0;

        if (i_accept && i_has) begin
            n_pos = r_pos + OFS_W'(1);
            if (!r_half_v) begin
                n_half_v    = 1'b1;
                n_half_byte = i_byte;
            end else begin
                n_half_v    = 1'b0;
                n_half_byte = '0;
                if (r_hp) begin
                    n_hp        = 1'b0;
                    w_cmd.a_v   = 1'b1;
                    w_cmd.ofs_a = r_hofs;
                    if (w_is_lo) begin
                        w_cmd.cp_a = CP_SUPP_BASE + CP_W'({r_hbits, w_unit[9:0]});
                    end else begin
                        w_cmd.cp_a = CP_REPL;
                        w_alone    = 1'b1;
                        w_alone_b  = 1'b1;
                    end
                end else begin
                    w_alone = 1'b1;
                end
            end
        end

        // unit handled on its own
        if (w_alone) begin
            if (w_is_hi) begin
                n_hp    = 1'b1;
                n_hbits = w_unit[9:0];
                n_hofs  = w_ofs;
            end else begin
                w_slot_v  = 1'b1;
                w_slot_cp = w_is_lo ? CP_REPL : CP_W'(w_unit);
            end
        end
        if (w_slot_v) begin
            if (w_alone_b) begin
                w_cmd.b_v   = 1'b1;
                w_cmd.cp_b  = w_slot_cp;
                w_cmd.ofs_b = w_ofs;
            end else begin
                w_cmd.a_v   = 1'b1;
                w_cmd.cp_a  = w_slot_cp;
                w_cmd.ofs_a = w_ofs;
            end
        end

        if (i_accept && i_end) begin
            w_cmd.sum_v    = 1'b1;
            w_cmd.consumed = n_hp ? n_hofs : (n_pos - OFS_W'(n_half_v));
            n_half_v    = 1'b0;
            n_half_byte = '0;
            n_hp        = 1'b0;
            n_hbits     = '0;
            n_hofs      = '0;
            n_pos       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_big_endian <= 1'b0;
            r_half_v     <= 1'b0;
            r_half_byte  <= '0;
            r_hp         <= 1'b0;
            r_hbits      <= '0;
            r_hofs       <= '0;
            r_pos        <= '0;
        end else begin
            r_big_endian <= n_big_endian;
            r_half_v     <= n_half_v;
            r_half_byte  <= n_half_byte;
            r_hp         <= n_hp;
            r_hbits      <= n_hbits;
            r_hofs       <= n_hofs;
            r_pos        <= n_pos;
        end
    end

    assign o_push = i_accept && (w_cmd.a_v || w_cmd.b_v || w_cmd.sum_v);
    assign o_cmd  = w_cmd;

endmodule

### hw/rtl/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module u16u8_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  u16u8_pkg::t_cmd        i_push_data,
    input  logic                   i_pop,
    output u16u8_pkg::t_cmd        o_pop_data,
    output u16u8_pkg::t_q_status   o_status
);
    import u16u8_pkg::*;

    t_cmd               r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr, n_wptr;
    logic [QPTR_W-1:0]  r_rptr, n_rptr;
    logic [QPTR_W:0]    r_count, n_count;
    logic               w_push;
    logic               w_pop;

    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wptr  = w_push ? r_wptr + QPTR_W'(1) : r_wptr;
        n_rptr  = w_pop  ? r_rptr + QPTR_W'(1) : r_rptr;
        n_count = r_count + (QPTR_W+1)'(w_push) - (QPTR_W+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    assign o_pop_data     = r_mem[r_rptr];
    assign o_status.full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

### hw/rtl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Walks each command and sends one utf-8 byte or summary word per cycle,
// while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module u16u8_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  u16u8_pkg::t_cmd                    i_cmd,
    input  u16u8_pkg::t_q_status               i_q_status,
    output logic                               o_pop,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [u16u8_pkg::MDATA_W-1:0]      o_m_tdata,
    output logic                               o_m_tuser,
    output logic                               o_m_tlast
);
    import u16u8_pkg::*;

    logic                r_busy,     n_busy;
    t_cmd                r_cmd,      n_cmd;
    t_seg                r_seg,      n_seg;
    logic [1:0]          r_idx,      n_idx;
    logic                r_out_v,    n_out_v;
    logic [MDATA_W-1:0]  r_out_data, n_out_data;
    logic                r_out_kind, n_out_kind;
    logic                r_out_last, n_out_last;

    logic [CP_W-1:0]     w_cp;
    logic [OFS_W-1:0]    w_ofs;
    logic [1:0]          w_len_m1;
    logic                w_seg_end;
    logic                w_has_next;
    t_seg                w_next_seg;
    t_seg                w_first_seg;
    logic                w_last;
    logic                w_adv;
    logic                w_load;

    assign w_cp     = (r_seg == SEG_B) ? r_cmd.cp_b  : r_cmd.cp_a;
    assign w_ofs    = (r_seg == SEG_B) ? r_cmd.ofs_b : r_cmd.ofs_a;
    assign w_len_m1 = utf8_len_m1(w_cp);

    always_comb begin
        w_has_next = 1'b0;
        w_next_seg = SEG_SUM;
        unique case (r_seg)
            SEG_A: begin
                if (r_cmd.b_v) begin
                    w_has_next = 1'b1;
                    w_next_seg = SEG_B;
                end else if (r_cmd.sum_v) begin
                    w_has_next = 1'b1;
                end
            end
            SEG_B: begin
                w_has_next = r_cmd.sum_v;
            end
            default: begin
                w_has_next = 1'b0;
            end
        endcase
    end

    always_comb begin
        priority if (i_cmd.a_v) begin
            w_first_seg = SEG_A;
        end else if (i_cmd.b_v) begin
            w_first_seg = SEG_B;
        end else begin
            w_first_seg = SEG_SUM;
        end
    end

    assign w_seg_end = (r_seg == SEG_SUM) || (r_idx == w_len_m1);
    assign w_last    = w_seg_end && !w_has_next;
    assign w_adv     = r_busy && (!r_out_v || i_m_tready);
    assign w_load    = !i_q_status.empty && (!r_busy || (w_adv && w_last));

    always_comb begin
        n_busy     = r_busy;
        n_cmd      = r_cmd;
        n_seg      = r_seg;
        n_idx      = r_idx;
        n_out_v    = r_out_v && !i_m_tready;
        n_out_data = r_out_data;
        n_out_kind = r_out_kind;
        n_out_last = r_out_last;

        if (w_adv) begin
            n_out_v    = 1'b1;
            n_out_last = w_last;
            if (r_seg == SEG_SUM) begin
                n_out_kind = 1'b1;
                n_out_data = {OUT_W'(r_cmd.consumed), OUT_W'(0), 8'h00};
            end else begin
                n_out_kind = 1'b0;
                n_out_data = {OUT_W'(0), OUT_W'(w_ofs), utf8_byte(w_cp, w_len_m1, r_idx)};
            end
            if (!w_seg_end) begin
                n_idx = r_idx + 2'd1;
            end else if (w_has_next) begin
                n_seg = w_next_seg;
                n_idx = 2'd0;
            end else begin
                n_busy = 1'b0;
            end
        end

        if (w_load) begin
            n_busy = 1'b1;
            n_cmd  = i_cmd;
            n_seg  = w_first_seg;
            n_idx  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_seg   <= SEG_A;
            r_idx   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_seg   <= n_seg;
            r_idx   <= n_idx;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out_data <= n_out_data;
        r_out_kind <= n_out_kind;
        r_out_last <= n_out_last;
    end

    assign o_pop      = w_load;
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

endmodule

### hw/rtl/utf16_to_utf8_with_offsets_unit.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_with_offsets_unit
// Throughput: one input word per cycle while the queue is not full; one output
// word per cycle while the output is not stalled, so an input word that yields
// n results holds the output side for n output words.
// A 4-entry command queue lets the input side run ahead of the output side.
// Reset clears all window state, selects little endian and empties the queue.
// ----------------------------------------------------------------------------
module utf16_to_utf8_with_offsets_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_data,   // big_endian
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [7:0]                         i_s_tdata,    // data_byte
    input  logic                               i_s_tuser,    // has_byte
    input  logic                               i_s_tlast,    // window_end
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // utf8_byte [7:0], source_offset [39:8], consumed_bytes [71:40]
    output logic [u16u8_pkg::MDATA_W-1:0]      o_m_tdata,
    output logic                               o_m_tuser,    // kind
    output logic                               o_m_tlast     // last
);
    import u16u8_pkg::*;

    logic       w_accept;
    logic       w_push;
    t_cmd       w_push_cmd;
    logic       w_pop;
    t_cmd       w_pop_cmd;
    t_q_status  w_q_status;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !w_q_status.full;
    assign w_accept    = i_s_tvalid && o_s_tready;

    u16u8_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_has      (i_s_tuser),
        .i_byte     (i_s_tdata),
        .i_end      (i_s_tlast),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    u16u8_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_cmd),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_cmd),
        .o_status    (w_q_status)
    );

    u16u8_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_pop_cmd),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // summary word always closes the results of its input word
    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tlast)
        else $error("summary word without last");

    a_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[39:0] == '0)
        else $error("summary word carries byte or offset");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[71:40] == '0)
        else $error("byte word carries a consumed count");

    a_q_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue full and empty at once");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.full |-> !w_push)
        else $error("push into a full queue");

endmodule
